// File: design/kce_pkg.sv
// shared types, constants and codes of the k-means clustering engine
package kce_pkg;

    // default sizes of the stores
    localparam int KCE_MAX_POINTS   = 1024;
    localparam int KCE_MAX_DIMS     = 32;
    localparam int KCE_MAX_CLUSTERS = 16;

    // register values after reset
    localparam logic [4:0]  RST_NUM_CLUSTERS = 5'd2;
    localparam logic [5:0]  RST_NUM_DIMS     = 6'd32;
    localparam logic [7:0]  RST_MAX_ITER     = 8'd100;
    localparam logic [15:0] RST_FIRST_ID     = 16'd0;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NUM_CLUSTERS = 2'd0,
        CFG_NUM_DIMS     = 2'd1,
        CFG_MAX_ITER     = 2'd2,
        CFG_FIRST_ID     = 2'd3
    } cfg_idx_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_TOO_FEW   = 2'd2,
        ST_READ      = 2'd3
    } run_status_t;

    // source of a centre store write
    typedef enum logic [1:0] {
        CEN_PT   = 2'd0,
        CEN_ZERO = 2'd1,
        CEN_QUOT = 2'd2
    } cen_src_t;

    typedef struct packed {
        logic [4:0]  num_clusters;
        logic [5:0]  num_dims;
        logic [7:0]  max_iterations;
        logic [15:0] first_cluster_id;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] coord_value;
        logic        last_of_point;
        logic        last_of_set;
        logic [3:0]  cluster_index;
        logic [4:0]  dim_index;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  iterations_used;
        logic [31:0] total_distance;
        logic [15:0] center_value;
        logic [15:0] cluster_id;
    } result_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic        pt_wr;
        logic        pt_rd;
        logic        cen_rd;
        logic        cen_wr;
        cen_src_t    cen_src;
        logic        row_set;
        logic        rd_capture;
        logic        sum_rd;
        logic        sum_wr;
        logic        use_bi;
        logic        cnt_clear;
        logic        cnt_inc;
        logic        sq_calc;
        logic        s_clear;
        logic        s_acc;
        logic        best_upd;
        logic        best_first;
        logic        sqrt_start;
        logic        tot_clear;
        logic        tot_acc;
        logic        div_start;
        logic        run_init;
        logic        run_fail;
        logic        iter_end;
        logic        out_load;
        run_status_t out_status;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic       sqrt_done;
        logic       div_done;
        logic       cnt_zero;
        logic       row_valid;
        logic       out_busy;
        logic       tot_eq_prev;
        logic [7:0] iter_val;
    } dp_stat_t;

endpackage

// File: design/kce_sqrt.sv
// iterative integer square root, two radicand bits per cycle
module kce_sqrt import kce_pkg::*; #(
    parameter int W = 38,
    localparam int H = W / 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] value,
    output logic         done,
    output logic [H-1:0] root
);

    localparam int RW  = H + 3;
    localparam int CNW = $clog2(H + 1);

    logic [W-1:0]   val_reg;
    logic [RW-1:0]  rem_reg;
    logic [H-1:0]   root_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [RW-1:0]  rem_sh;
    logic [RW-1:0]  trial;
    logic           ge;

    // one digit step
    always_comb
    begin
        rem_sh = {rem_reg[RW-3:0], val_reg[W-1:W-2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNW'(H);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // radicand, remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[H-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: design/kce_div.sv
// restoring divider, one quotient bit per cycle
module kce_div import kce_pkg::*; #(
    parameter int NW = 27,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  q_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  dv_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DW:0]    rsh;
    logic [DW:0]    diff;
    logic           ge;

    // one quotient bit
    always_comb
    begin
        rsh  = {rem_reg, q_reg[NW-1]};
        diff = rsh - {1'b0, dv_reg};
        ge   = (rsh >= {1'b0, dv_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : rsh[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: design/kce_ctrl.sv
// controller state machine: loading, seeding, lloyd iterations and read-back
module kce_ctrl import kce_pkg::*; #(
    parameter int MAX_POINTS   = KCE_MAX_POINTS,
    parameter int MAX_DIMS     = KCE_MAX_DIMS,
    parameter int MAX_CLUSTERS = KCE_MAX_CLUSTERS,
    localparam int PIW = $clog2(MAX_POINTS),
    localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  item_t          item,
    input  logic           item_valid,
    output logic           item_stall,
    output dp_cmd_t        cmd,
    output logic [PIW-1:0] pidx,
    output logic [CIW-1:0] cidx,
    output logic [DIW-1:0] didx,
    input  dp_stat_t       stat
);

    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(MAX_CLUSTERS + 1);
    localparam int DW = $clog2(MAX_DIMS + 1);

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_READ     = 19'h00002,
        S_START    = 19'h00004,
        S_SEED_RD  = 19'h00008,
        S_SEED_WR  = 19'h00010,
        S_ITER     = 19'h00020,
        S_AS_RD    = 19'h00040,
        S_AS_SQ    = 19'h00080,
        S_AS_ACC   = 19'h00100,
        S_AS_CMP   = 19'h00200,
        S_SUM_RD   = 19'h00400,
        S_SUM_WR   = 19'h00800,
        S_SQRT     = 19'h01000,
        S_UPD_CHK  = 19'h02000,
        S_UPD_RD   = 19'h04000,
        S_UPD_DIV  = 19'h08000,
        S_UPD_WAIT = 19'h10000,
        S_ITER_END = 19'h20000,
        S_DONE     = 19'h40000
    } state_t;

    state_t      state_reg, state_next;
    logic [NW-1:0] pl_reg, pl_next;
    logic [DW-1:0] cc_reg, cc_next;
    logic [NW-1:0] p_reg, p_next;
    logic [KW-1:0] c_reg, c_next;
    logic [DW-1:0] d_reg, d_next;
    run_status_t rs_reg, rs_next;

    logic [KW-1:0] k_w;
    logic [DW-1:0] dims_w;
    logic [7:0]    lim;
    logic          accept;
    logic          d_last;

    // clamped configuration
    always_comb
    begin
        if (cfg.num_clusters == 5'd0)
            k_w = KW'(1);
        else if (32'(cfg.num_clusters) > MAX_CLUSTERS)
            k_w = KW'(MAX_CLUSTERS);
        else
            k_w = KW'(cfg.num_clusters);
        if (cfg.num_dims == 6'd0)
            dims_w = DW'(1);
        else if (32'(cfg.num_dims) > MAX_DIMS)
            dims_w = DW'(MAX_DIMS);
        else
            dims_w = DW'(cfg.num_dims);
        lim = (cfg.max_iterations == 8'd0) ? 8'd1 : cfg.max_iterations;
    end

    assign item_stall = (state_reg != S_IDLE) || stat.out_busy;
    assign accept     = item_valid && !item_stall;
    assign d_last     = ((d_reg + DW'(1)) == dims_w);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        pl_next    = pl_reg;
        cc_next    = cc_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        rs_next    = rs_reg;
        cmd        = '0;
        cmd.cen_src    = CEN_PT;
        cmd.out_status = rs_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd)
                    begin
                        cmd.rd_capture = 1'b1;
                        state_next     = S_READ;
                    end
                    else
                    begin
                        if ((32'(pl_reg) < MAX_POINTS) && (cc_reg < dims_w))
                            cmd.pt_wr = 1'b1;
                        if (cc_reg < dims_w)
                            cc_next = cc_reg + DW'(1);
                        if (item.last_of_point || item.last_of_set)
                        begin
                            if (32'(pl_reg) < MAX_POINTS)
                                pl_next = pl_reg + NW'(1);
                            cc_next = '0;
                        end
                        if (item.last_of_set)
                            state_next = S_START;
                    end
                end
            end
            S_READ:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_READ;
                state_next     = S_IDLE;
            end
            S_START:
            begin
                c_next = '0;
                d_next = '0;
                if (32'(pl_reg) < 32'(k_w))
                begin
                    cmd.run_fail = 1'b1;
                    rs_next      = ST_TOO_FEW;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.run_init = 1'b1;
                    state_next   = S_SEED_RD;
                end
            end
            // seed centre c with point c, clear unused dims of never-written rows
            S_SEED_RD:
            begin
                cmd.pt_rd  = 1'b1;
                state_next = S_SEED_WR;
            end
            S_SEED_WR:
            begin
                if (d_reg < dims_w)
                begin
                    cmd.cen_wr  = 1'b1;
                    cmd.cen_src = CEN_PT;
                end
                else if (!stat.row_valid)
                begin
                    cmd.cen_wr  = 1'b1;
                    cmd.cen_src = CEN_ZERO;
                end
                if (d_reg == DW'(MAX_DIMS - 1))
                begin
                    cmd.row_set = 1'b1;
                    d_next      = '0;
                    c_next      = c_reg + KW'(1);
                    state_next  = ((c_reg + KW'(1)) == k_w) ? S_ITER : S_SEED_RD;
                end
                else
                begin
                    d_next     = d_reg + DW'(1);
                    state_next = S_SEED_RD;
                end
            end
            S_ITER:
            begin
                cmd.cnt_clear = 1'b1;
                cmd.tot_clear = 1'b1;
                cmd.s_clear   = 1'b1;
                p_next        = '0;
                c_next        = '0;
                d_next        = '0;
                state_next    = S_AS_RD;
            end
            // squared distance of point p to centre c, one coordinate per pass
            S_AS_RD:
            begin
                cmd.pt_rd  = 1'b1;
                cmd.cen_rd = 1'b1;
                state_next = S_AS_SQ;
            end
            S_AS_SQ:
            begin
                cmd.sq_calc = 1'b1;
                state_next  = S_AS_ACC;
            end
            S_AS_ACC:
            begin
                cmd.s_acc = 1'b1;
                if (d_last)
                begin
                    d_next     = '0;
                    state_next = S_AS_CMP;
                end
                else
                begin
                    d_next     = d_reg + DW'(1);
                    state_next = S_AS_RD;
                end
            end
            S_AS_CMP:
            begin
                cmd.best_upd   = 1'b1;
                cmd.best_first = (c_reg == '0);
                cmd.s_clear    = 1'b1;
                if ((c_reg + KW'(1)) == k_w)
                begin
                    c_next     = '0;
                    state_next = S_SUM_RD;
                end
                else
                begin
                    c_next     = c_reg + KW'(1);
                    state_next = S_AS_RD;
                end
            end
            // add the point into the sums of its nearest cluster
            S_SUM_RD:
            begin
                cmd.use_bi = 1'b1;
                cmd.pt_rd  = 1'b1;
                cmd.sum_rd = 1'b1;
                state_next = S_SUM_WR;
            end
            S_SUM_WR:
            begin
                cmd.use_bi = 1'b1;
                cmd.sum_wr = 1'b1;
                if (d_last)
                begin
                    d_next         = '0;
                    cmd.cnt_inc    = 1'b1;
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
                else
                begin
                    d_next     = d_reg + DW'(1);
                    state_next = S_SUM_RD;
                end
            end
            S_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.tot_acc = 1'b1;
                    if ((p_reg + NW'(1)) == pl_reg)
                    begin
                        c_next     = '0;
                        state_next = S_UPD_CHK;
                    end
                    else
                    begin
                        p_next     = p_reg + NW'(1);
                        state_next = S_AS_RD;
                    end
                end
            end
            // new centres of non-empty clusters
            S_UPD_CHK:
            begin
                if (c_reg == k_w)
                    state_next = S_ITER_END;
                else if (stat.cnt_zero)
                    c_next = c_reg + KW'(1);
                else
                begin
                    d_next     = '0;
                    state_next = S_UPD_RD;
                end
            end
            S_UPD_RD:
            begin
                cmd.sum_rd = 1'b1;
                state_next = S_UPD_DIV;
            end
            S_UPD_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_UPD_WAIT;
            end
            S_UPD_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.cen_wr  = 1'b1;
                    cmd.cen_src = CEN_QUOT;
                    if (d_last)
                    begin
                        d_next     = '0;
                        c_next     = c_reg + KW'(1);
                        state_next = S_UPD_CHK;
                    end
                    else
                    begin
                        d_next     = d_reg + DW'(1);
                        state_next = S_UPD_RD;
                    end
                end
            end
            S_ITER_END:
            begin
                cmd.iter_end = 1'b1;
                if (stat.tot_eq_prev)
                begin
                    rs_next    = ST_CONVERGED;
                    state_next = S_DONE;
                end
                else if (({1'b0, stat.iter_val} + 9'd1) == {1'b0, lim})
                begin
                    rs_next    = ST_LIMIT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ITER;
                end
            end
            S_DONE:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_status = rs_reg;
                pl_next        = '0;
                cc_next        = '0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // store indexes for the datapath
    always_comb
    begin
        cidx = c_reg[CIW-1:0];
        if (state_reg == S_IDLE)
        begin
            pidx = pl_reg[PIW-1:0];
            didx = cc_reg[DIW-1:0];
        end
        else if ((state_reg == S_SEED_RD) || (state_reg == S_SEED_WR))
        begin
            pidx = PIW'(c_reg);
            didx = d_reg[DIW-1:0];
        end
        else
        begin
            pidx = p_reg[PIW-1:0];
            didx = d_reg[DIW-1:0];
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pl_reg    <= '0;
            cc_reg    <= '0;
            p_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            rs_reg    <= ST_CONVERGED;
        end
        else
        begin
            state_reg <= state_next;
            pl_reg    <= pl_next;
            cc_reg    <= cc_next;
            p_reg     <= p_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            rs_reg    <= rs_next;
        end
    end

endmodule

// File: design/kce_dpath.sv
// datapath: point, centre and sum stores, distance arithmetic, totals and result register
module kce_dpath import kce_pkg::*; #(
    parameter int MAX_POINTS   = KCE_MAX_POINTS,
    parameter int MAX_DIMS     = KCE_MAX_DIMS,
    parameter int MAX_CLUSTERS = KCE_MAX_CLUSTERS,
    localparam int PIW = $clog2(MAX_POINTS),
    localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  item_t          item,
    input  dp_cmd_t        cmd,
    input  logic [PIW-1:0] pidx,
    input  logic [CIW-1:0] cidx,
    input  logic [DIW-1:0] didx,
    output dp_stat_t       stat,
    output logic           result_valid,
    input  logic           result_stall,
    output result_t        result
);

    localparam int PDEPTH = MAX_POINTS * MAX_DIMS;
    localparam int CDEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int PAW    = $clog2(PDEPTH);
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int CNTW   = $clog2(MAX_POINTS + 1);
    localparam int SUMW   = 16 + CNTW;
    localparam int SQW    = 32 + $clog2(MAX_DIMS);
    localparam int SQE    = SQW + (SQW % 2);
    localparam int RTW    = SQE / 2;

    // stores
    logic [15:0]     pt_mem  [PDEPTH];
    logic [15:0]     cen_mem [CDEPTH];
    logic [SUMW-1:0] sum_mem [CDEPTH];

    logic [15:0]     pt_q;
    logic [15:0]     cen_q;
    logic [SUMW-1:0] sum_q;

    logic [CNTW-1:0] cnt_reg [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] row_valid_reg;

    logic [31:0]     sq_reg;
    logic [SQW-1:0]  s_reg;
    logic [SQW-1:0]  best_reg;
    logic [CIW-1:0]  bi_reg;
    logic [31:0]     total_reg;
    logic [31:0]     cur_reg;
    logic [31:0]     prev_reg;
    logic [7:0]      iter_reg;
    logic            rd_ok_reg;
    logic [3:0]      rd_ci_reg;
    logic            result_valid_reg;
    result_t         result_reg;

    logic [PAW-1:0]  pt_addr;
    logic [CAW-1:0]  cen_waddr;
    logic [CAW-1:0]  cen_raddr;
    logic [CAW-1:0]  sum_addr;
    logic [CIW-1:0]  sel_c;
    logic            rd_in_range;
    logic [15:0]     cen_wdata;
    logic [SUMW-1:0] sum_wdata;
    logic [15:0]     ad;
    logic [32:0]     tot_sum;
    logic            cnt_zero;
    logic            sqrt_done;
    logic [RTW-1:0]  root;
    logic            div_done;
    logic [SUMW-1:0] quot;

    // addresses
    always_comb
    begin
        sel_c       = cmd.use_bi ? bi_reg : cidx;
        pt_addr     = PAW'(pidx) * PAW'(MAX_DIMS) + PAW'(didx);
        cen_waddr   = CAW'(cidx) * CAW'(MAX_DIMS) + CAW'(didx);
        sum_addr    = CAW'(sel_c) * CAW'(MAX_DIMS) + CAW'(didx);
        rd_in_range = (32'(item.cluster_index) < MAX_CLUSTERS)
                      && (32'(item.dim_index) < MAX_DIMS);
        if (cmd.rd_capture)
            cen_raddr = rd_in_range
                        ? CAW'(32'(item.cluster_index) * MAX_DIMS + 32'(item.dim_index))
                        : '0;
        else
            cen_raddr = cen_waddr;
    end

    // write data
    always_comb
    begin
        cnt_zero = (cnt_reg[sel_c] == '0);
        case (cmd.cen_src)
            CEN_PT:   cen_wdata = pt_q;
            CEN_QUOT: cen_wdata = quot[15:0];
            default:  cen_wdata = 16'd0;
        endcase
        sum_wdata = SUMW'(pt_q) + (cnt_zero ? '0 : sum_q);
        ad        = (pt_q >= cen_q) ? (pt_q - cen_q) : (cen_q - pt_q);
        tot_sum   = {1'b0, total_reg} + 33'(root);
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (cmd.pt_wr)
            pt_mem[pt_addr] <= item.coord_value;
        if (cmd.pt_rd)
            pt_q <= pt_mem[pt_addr];
    end

    // centre store
    always_ff @(posedge clk)
    begin
        if (cmd.cen_wr)
            cen_mem[cen_waddr] <= cen_wdata;
        if (cmd.cen_rd || cmd.rd_capture)
            cen_q <= cen_mem[cen_raddr];
    end

    // coordinate sums
    always_ff @(posedge clk)
    begin
        if (cmd.sum_wr)
            sum_mem[sum_addr] <= sum_wdata;
        if (cmd.sum_rd)
            sum_q <= sum_mem[sum_addr];
    end

    // member counts and centre row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLUSTERS; i++)
                cnt_reg[i] <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_clear)
            begin
                for (int i = 0; i < MAX_CLUSTERS; i++)
                    cnt_reg[i] <= '0;
            end
            else if (cmd.cnt_inc)
                cnt_reg[bi_reg] <= cnt_reg[bi_reg] + CNTW'(1);
            if (cmd.row_set)
                row_valid_reg[cidx] <= 1'b1;
        end
    end

    // distance accumulation and nearest centre
    always_ff @(posedge clk)
    begin
        if (cmd.sq_calc)
            sq_reg <= {16'd0, ad} * {16'd0, ad};
        if (cmd.s_clear)
            s_reg <= '0;
        else if (cmd.s_acc)
            s_reg <= s_reg + SQW'(sq_reg);
        if (cmd.best_upd && (cmd.best_first || (s_reg < best_reg)))
        begin
            best_reg <= s_reg;
            bi_reg   <= cidx;
        end
        if (cmd.rd_capture)
        begin
            rd_ok_reg <= rd_in_range && row_valid_reg[CIW'(item.cluster_index)];
            rd_ci_reg <= item.cluster_index;
        end
    end

    // totals and iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            cur_reg   <= '0;
            prev_reg  <= '1;
            iter_reg  <= '0;
        end
        else
        begin
            if (cmd.tot_clear)
                total_reg <= '0;
            else if (cmd.tot_acc)
                total_reg <= tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
            if (cmd.run_init)
            begin
                prev_reg <= '1;
                iter_reg <= '0;
            end
            else if (cmd.run_fail)
            begin
                iter_reg <= '0;
                cur_reg  <= '0;
            end
            else if (cmd.iter_end)
            begin
                iter_reg <= iter_reg + 8'd1;
                cur_reg  <= total_reg;
                prev_reg <= total_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.out_load)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.status          <= cmd.out_status;
            result_reg.iterations_used <= iter_reg;
            result_reg.total_distance  <= cur_reg;
            if (cmd.out_status == ST_READ)
            begin
                result_reg.center_value <= rd_ok_reg ? cen_q : 16'd0;
                result_reg.cluster_id   <= cfg.first_cluster_id + {12'd0, rd_ci_reg};
            end
            else
            begin
                result_reg.center_value <= 16'd0;
                result_reg.cluster_id   <= 16'd0;
            end
        end
    end

    // shared iterative units
    kce_sqrt #(
        .W (SQE)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value (SQE'(best_reg)),
        .done  (sqrt_done),
        .root  (root)
    );

    kce_div #(
        .NW (SUMW),
        .DW (CNTW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_q),
        .divisor  (cnt_reg[cidx]),
        .done     (div_done),
        .quotient (quot)
    );

    // status
    always_comb
    begin
        stat.sqrt_done   = sqrt_done;
        stat.div_done    = div_done;
        stat.cnt_zero    = cnt_zero;
        stat.row_valid   = row_valid_reg[cidx];
        stat.out_busy    = result_valid_reg && result_stall;
        stat.tot_eq_prev = (total_reg == prev_reg);
        stat.iter_val    = iter_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a new result never overwrites one still held by the receiver
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(result_valid_reg && result_stall))
        else $error("result loaded while previous transaction stalled");

    // a quotient is written only once the divider has finished
    a_quot_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cen_wr && (cmd.cen_src == CEN_QUOT)) |-> div_done)
        else $error("centre written from unfinished division");

    // the saturating total never falls while accumulating
    a_tot_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tot_acc && !cmd.tot_clear) |=> (total_reg >= $past(total_reg)))
        else $error("total distance decreased");

endmodule

// File: design/kmeans_clustering_engine.sv
// Load: one coordinate per cycle while item_stall is low, no result. Centre read: the centre
// value is registered, then loaded into the result register. A run follows the last coordinate
// of the set: seeding, then lloyd iterations, using the shared square-root and divider units
// and the single-port stores.
// Reset is asynchronous, active low: control state clears at once, the centre store reads zero
// until seeded (row valid bits), the point store is undefined until written.
module kmeans_clustering_engine import kce_pkg::*; #(
    parameter int MAX_POINTS   = KCE_MAX_POINTS,
    parameter int MAX_DIMS     = KCE_MAX_DIMS,
    parameter int MAX_CLUSTERS = KCE_MAX_CLUSTERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam int PIW = $clog2(MAX_POINTS);
    localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    cfg_t           cfg_reg;
    dp_cmd_t        cmd;
    dp_stat_t       stat;
    logic [PIW-1:0] pidx;
    logic [CIW-1:0] cidx;
    logic [DIW-1:0] didx;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_clusters     <= RST_NUM_CLUSTERS;
            cfg_reg.num_dims         <= RST_NUM_DIMS;
            cfg_reg.max_iterations   <= RST_MAX_ITER;
            cfg_reg.first_cluster_id <= RST_FIRST_ID;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_CLUSTERS: cfg_reg.num_clusters     <= cfg_data[4:0];
                CFG_NUM_DIMS:     cfg_reg.num_dims         <= cfg_data[5:0];
                CFG_MAX_ITER:     cfg_reg.max_iterations   <= cfg_data[7:0];
                CFG_FIRST_ID:     cfg_reg.first_cluster_id <= cfg_data;
            endcase
        end
    end

    kce_ctrl #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_DIMS     (MAX_DIMS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .pidx       (pidx),
        .cidx       (cidx),
        .didx       (didx),
        .stat       (stat)
    );

    kce_dpath #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_DIMS     (MAX_DIMS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item         (item),
        .cmd          (cmd),
        .pidx         (pidx),
        .cidx         (cidx),
        .didx         (didx),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: test/kmeans_clustering_engine_tb.sv
`timescale 1ns / 1ps
// testbench of the k-means clustering engine: a directed table, then random point sets
module kmeans_clustering_engine_tb;
    import kce_pkg::*;

    localparam int NP    = KCE_MAX_POINTS;
    localparam int ND    = KCE_MAX_DIMS;
    localparam int NC    = KCE_MAX_CLUSTERS;
    localparam int LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_NUM_CLUSTERS;
    logic [15:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;

    // behavioural copy of the engine state
    logic [15:0] pts [NP*ND];
    bit          written [NP*ND];
    logic [15:0] cen [NC*ND];
    int unsigned npts, ccnt;
    logic [31:0] cur_tot, prev_tot;
    logic [7:0]  iters;
    logic [4:0]  r_nc;
    logic [5:0]  r_nd;
    logic [7:0]  r_mi;
    logic [15:0] r_fid;

    result_t     pending_results [$];
    stim_row_t   tbl [$];
    result_t     got_exp;
    int          fails = 0;
    int          cycles = 0;
    int          items_sent = 0;
    bit          quiet = 1'b0;
    int          hold_req = 0, hold_seen = 0, hold_cnt = 0, stall_roll;

    always #1 clk = ~clk;

    kmeans_clustering_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    function automatic int clamp_k(logic [4:0] v);
        return (v < 1) ? 1 : (v > NC) ? NC : int'(v);
    endfunction

    function automatic int clamp_dims(logic [5:0] v);
        return (v < 1) ? 1 : (v > ND) ? ND : int'(v);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000000000000000;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // seeding and lloyd iterations over the loaded set
    task automatic lloyd_run(output run_status_t st);
        int k, dims, lim, bi, p, c, d;
        longint unsigned tot, best, s;
        longint df;
        longint unsigned sums [NC*ND];
        int unsigned cnt [NC];
        k = clamp_k(r_nc);
        dims = clamp_dims(r_nd);
        lim = (r_mi < 1) ? 1 : int'(r_mi);
        if (npts < k)
        begin
            iters = '0;
            cur_tot = '0;
            st = ST_TOO_FEW;
            return;
        end
        for (c = 0; c < k; c++)
            for (d = 0; d < dims; d++)
                cen[c*ND+d] = pts[c*ND+d];
        prev_tot = '1;
        iters = '0;
        st = ST_LIMIT;
        while (iters < lim)
        begin
            tot = 0;
            foreach (sums[i]) sums[i] = 0;
            foreach (cnt[i]) cnt[i] = 0;
            for (p = 0; p < npts; p++)
            begin
                best = 0;
                bi = 0;
                for (c = 0; c < k; c++)
                begin
                    s = 0;
                    for (d = 0; d < dims; d++)
                    begin
                        df = longint'(pts[p*ND+d]) - longint'(cen[c*ND+d]);
                        s += longint'(df * df);
                    end
                    if (c == 0 || s < best)
                    begin
                        best = s;
                        bi = c;
                    end
                end
                cnt[bi]++;
                for (d = 0; d < dims; d++)
                    sums[bi*ND+d] += pts[p*ND+d];
                tot += isqrt(best);
                if (tot > 64'hFFFFFFFF) tot = 64'hFFFFFFFF;
            end
            // empty clusters keep their centre
            for (c = 0; c < k; c++)
                if (cnt[c] != 0)
                    for (d = 0; d < dims; d++)
                        cen[c*ND+d] = 16'(sums[c*ND+d] / cnt[c]);
            iters++;
            cur_tot = tot[31:0];
            if (cur_tot == prev_tot)
            begin
                st = ST_CONVERGED;
                break;
            end
            prev_tot = cur_tot;
        end
    endtask

    // expected outcome of one accepted transaction
    task automatic cluster_predict(input item_t it, output bit has, output result_t r);
        int dims;
        run_status_t st;
        r = '0;
        has = 1'b0;
        if (it.cmd)
        begin
            r.status          = ST_READ;
            r.iterations_used = iters;
            r.total_distance  = cur_tot;
            r.center_value    = cen[it.cluster_index*ND + it.dim_index];
            r.cluster_id      = r_fid + 16'(it.cluster_index);
            has = 1'b1;
        end
        else
        begin
            dims = clamp_dims(r_nd);
            if (npts < NP && ccnt < dims)
            begin
                pts[npts*ND+ccnt] = it.coord_value;
                written[npts*ND+ccnt] = 1'b1;
            end
            if (ccnt < dims) ccnt++;
            if (it.last_of_point || it.last_of_set)
            begin
                if (npts < NP) npts++;
                ccnt = 0;
            end
            if (it.last_of_set)
            begin
                lloyd_run(st);
                npts = 0;
                ccnt = 0;
                r.status          = st;
                r.iterations_used = iters;
                r.total_distance  = cur_tot;
                has = 1'b1;
            end
        end
    endtask

    function automatic item_t mk(bit cmd, logic [15:0] v, bit lop, bit los, int ci, int di);
        item_t it;
        it = item_t'(28'($urandom));
        it.cmd = cmd;
        if (!cmd)
        begin
            it.coord_value   = v;
            it.last_of_point = lop;
            it.last_of_set   = los;
        end
        else
        begin
            it.cluster_index = 4'(ci);
            it.dim_index     = 5'(di);
        end
        return it;
    endfunction

    function automatic item_t rand_read(int kmax, int dmax);
        int ci, di;
        ci = ($urandom_range(0, 3) != 0) ? $urandom_range(0, kmax - 1) : $urandom_range(0, NC - 1);
        di = ($urandom_range(0, 3) != 0) ? $urandom_range(0, dmax - 1) : $urandom_range(0, ND - 1);
        return mk(1'b1, '0, 1'b0, 1'b0, ci, di);
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_row(item_t it, bit typed = 1'b0, result_t e = '0);
        stim_row_t row;
        row.it = it;
        row.typed = typed;
        row.exp = e;
        tbl.push_back(row);
    endfunction

    // one input transaction, then at times a random gap
    task automatic send(item_t it, bit typed = 1'b0, result_t tv = '0);
        bit has;
        result_t r;
        int g;
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        items_sent++;
        cluster_predict(it, has, r);
        if (has) pending_results.push_back(typed ? tv : r);
        g = $urandom_range(0, 99);
        if (!quiet && g < 40)
        begin
            item_valid <= 1'b0;
            repeat ((g < 37) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
        end
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [15:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        case (idx)
            CFG_NUM_CLUSTERS: r_nc = v[4:0];
            CFG_NUM_DIMS:     r_nd = v[5:0];
            CFG_MAX_ITER:     r_mi = v[7:0];
            CFG_FIRST_ID:     r_fid = v;
        endcase
    endtask

    task automatic configure(logic [15:0] nc, logic [15:0] nd, logic [15:0] mi, logic [15:0] fid);
        set_reg(CFG_NUM_CLUSTERS, nc);
        set_reg(CFG_NUM_DIMS, nd);
        set_reg(CFG_MAX_ITER, mi);
        set_reg(CFG_FIRST_ID, fid);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // one point: usually full length, sometimes with extra or missing coordinates
    task automatic gen_point(bit last);
        int dims, len, cand, d, i, sel;
        bit ok;
        dims = clamp_dims(r_nd);
        len = dims;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            len = dims + $urandom_range(1, 2);
        else if (sel == 1 && dims > 1)
        begin
            // short point only where the missing coordinates hold earlier data
            cand = $urandom_range(1, dims - 1);
            ok = 1'b1;
            if (npts < NP)
                for (d = cand; d < dims; d++)
                    if (!written[npts*ND+d]) ok = 1'b0;
            if (ok) len = cand;
        end
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 8) send(rand_read(clamp_k(r_nc), dims));
            send(mk(1'b0, rand_coord(), (i == len - 1) && (!last || $urandom_range(0, 1)),
                    last && (i == len - 1), 0, 0));
        end
    endtask

    // receiver stalls: random, occasional bursts, and one long hold on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            result_stall <= 1'b1;
        end
        else if (quiet)
            result_stall <= 1'b0;
        else
        begin
            stall_roll = $urandom_range(0, 199);
            if (stall_roll == 0) hold_cnt = $urandom_range(20, 60);
            result_stall <= (stall_roll < 50);
        end
    end

    // result checking against the oldest expectation
    task automatic chk(string nm, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, nm, e, a);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %p", $time, result);
                fails++;
            end
            else
            begin
                got_exp = pending_results.pop_front();
                chk("status", got_exp.status, result.status);
                chk("iterations_used", got_exp.iterations_used, result.iterations_used);
                chk("total_distance", got_exp.total_distance, result.total_distance);
                chk("center_value", got_exp.center_value, result.center_value);
                chk("cluster_id", got_exp.cluster_id, result.cluster_id);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int set_no, k, n, dims, p, nreads, i, target;
        logic [15:0] nc, nd, mi;

        foreach (pts[j]) pts[j] = '0;
        foreach (cen[j]) cen[j] = '0;
        npts = 0;
        ccnt = 0;
        cur_tot = '0;
        prev_tot = '1;
        iters = '0;
        r_nc = RST_NUM_CLUSTERS;
        r_nd = RST_NUM_DIMS;
        r_mi = RST_MAX_ITER;
        r_fid = RST_FIRST_ID;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, two coordinates per point
        set_reg(CFG_NUM_DIMS, 16'd2);
        cfg_write <= 1'b0;
        @(posedge clk);
        add_row(mk(1'b1, '0, 1'b0, 1'b0, 0, 0), 1'b1, '{status: ST_READ, default: '0});
        add_row(mk(1'b1, '0, 1'b0, 1'b0, 15, 31), 1'b1,
                '{status: ST_READ, cluster_id: 16'd15, default: '0});
        // too few points
        add_row(mk(1'b0, 16'h0000, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'hFFFF, 1'b0, 1'b1, 0, 0), 1'b1, '{status: ST_TOO_FEW, default: '0});
        // extremes, with an extra coordinate in the second point
        add_row(mk(1'b0, 16'h0000, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'h0000, 1'b1, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'hFFFF, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'hFFFF, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'h1234, 1'b1, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'hFFFF, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'hFFFF, 1'b0, 1'b1, 0, 0));
        add_row(mk(1'b1, '0, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b1, '0, 1'b0, 1'b0, 1, 1));
        add_row(mk(1'b1, '0, 1'b0, 1'b0, 2, 0));
        add_row(mk(1'b1, '0, 1'b0, 1'b0, 5, 31));
        // equal seeds, ties go to the lower cluster
        add_row(mk(1'b0, 16'd100, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'd100, 1'b1, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'd100, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'd100, 1'b1, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'd200, 1'b0, 1'b0, 0, 0));
        add_row(mk(1'b0, 16'd0, 1'b0, 1'b1, 0, 0));
        add_row(mk(1'b1, '0, 1'b0, 1'b0, 1, 0));
        add_row(mk(1'b1, '0, 1'b0, 1'b0, 0, 1));
        foreach (tbl[j]) send(tbl[j].it, tbl[j].typed, tbl[j].exp);
        drain();

        // random point sets
        target = items_sent + RANDOM_ITEMS;
        set_no = 0;
        while (items_sent < target)
        begin
            case (set_no)
                0: configure(16'd16, 16'd1, 16'd1, 16'hFFFF);
                1: configure(16'd1, 16'd32, 16'd255, 16'h0000);
                2: configure(16'd0, 16'd0, 16'd0, 16'h1234);
                3: configure(16'd31, 16'd63, 16'd3, 16'hFFF0);
                default:
                    if ($urandom_range(0, 2) == 0)
                    begin
                        nc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
                        case ($urandom_range(0, 9))
                            0, 1: nd = $urandom_range(0, 63);
                            2: nd = 16'd32;
                            default: nd = $urandom_range(1, 4);
                        endcase
                        if (clamp_k(nc[4:0]) * clamp_dims(nd[5:0]) > 64) nd = $urandom_range(1, 4);
                        case ($urandom_range(0, 9))
                            0: mi = 16'($urandom);
                            1, 2: mi = $urandom_range(16, 100);
                            default: mi = $urandom_range(1, 15);
                        endcase
                        configure(nc, nd, mi, 16'($urandom));
                    end
            endcase
            quiet = (set_no % 7 == 5);
            k = clamp_k(r_nc);
            dims = clamp_dims(r_nd);
            if ($urandom_range(0, 7) == 0 && k > 1)
                n = $urandom_range(1, k - 1);
            else
                n = $urandom_range(k, k + 5);
            for (p = 0; p < n; p++) gen_point(p == n - 1);
            nreads = $urandom_range(4, 8);
            for (i = 0; i < nreads; i++) send(rand_read(k, dims));
            drain();
            // long receiver hold while reads keep coming
            if (set_no == 3)
            begin
                quiet = 1'b1;
                hold_req++;
                for (i = 0; i < 12; i++) send(rand_read(k, dims));
                drain();
            end
            quiet = 1'b0;
            set_no++;
        end

        drain();
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
design/kce_pkg.sv
design/kce_sqrt.sv
design/kce_div.sv
design/kce_ctrl.sv
design/kce_dpath.sv
design/kmeans_clustering_engine.sv
test/kmeans_clustering_engine_tb.sv
